// File: hw/rtl/char_lcd_nibble_interface_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD nibble interface
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CLNI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CLNI_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CLNI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/clni_pkg.sv
// ---------------------------------------------------------------------------
// Character LCD nibble interface package
// Request codes, job kinds and the constant tables of the LCD interface.
// ---------------------------------------------------------------------------
`default_nettype none

package clni_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_INSTR  = 3'd2,
    CMD_CHAR   = 3'd3,
    CMD_CURSOR = 3'd4,
    CMD_NUMBER = 3'd5,
    CMD_POINT  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_INIT   = 2'd0,
    JOB_BYTE   = 2'd1,
    JOB_DIGITS = 2'd2
  } job_e;

  localparam logic [7:0] INSTR_CLEAR = 8'h01;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_POINT = 8'h2e;
  localparam logic [2:0] INIT_LAST   = 3'd6;
  localparam logic [2:0] POINT_EXP   = 3'd2;
  localparam logic [2:0] POINT_DIGITS = 3'd3;

  function automatic logic [7:0] power_up_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0e;
      3'd3:    b = 8'h0c;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h01;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hc0;
      2'd2:    b = 8'h94;
      default: b = 8'hd4;
    endcase
    return b;
  endfunction

  function automatic logic [16:0] pow10(input logic [2:0] e);
    logic [16:0] p;
    unique case (e)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd100000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/char_lcd_nibble_interface.sv
// An accepted request loads the job registers; its first strobe then moves into the output register when not stalled.
// Throughput: one strobe per cycle while the output is not stalled; a request gives 2 to 14 strobes, or none.
// The output stall sets the rate; the next request is accepted in the cycle the
// last strobe of the current one moves into the output register.
// Reset clears the job and output valid flags; no strobe is pending after it.
// ---------------------------------------------------------------------------
// Character LCD nibble interface
// Turns display requests into 4-bit LCD bus strobes, high nibble first.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface
  import clni_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [2:0]  row_i,
  input  wire logic [4:0]  column_i,
  input  wire logic [13:0] number_i,
  input  wire logic [2:0]  digit_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             register_select_o,
  output logic [3:0]       nibble_o,
  output logic             last_o
);

  localparam logic [2:0] MaxDig = 3'(MAX_DIGITS);

  logic        active_q, active_d;
  job_e        job_q;
  logic        rs_q;
  logic [7:0]  byte_q;
  logic [13:0] val_q;
  logic [2:0]  pos_q;
  logic        hi_q;
  logic [2:0]  exp_q;
  logic        pt_q;

  logic        out_valid_q, out_valid_d;
  logic        out_rs_q;
  logic [3:0]  out_nib_q;
  logic        out_last_q;

  logic        ld_go;
  job_e        ld_job;
  logic        ld_rs;
  logic [7:0]  ld_byte;
  logic [13:0] ld_val;
  logic [2:0]  ld_exp;
  logic        ld_pt;
  logic [2:0]  ld_n;
  logic [2:0]  ndig;
  logic [1:0]  row_idx;
  logic [16:0] cap;

  logic [16:0] pw;
  logic [16:0] thr;
  logic [16:0] sel_thr;
  logic [3:0]  digit;
  logic [7:0]  cur_byte;
  logic        byte_end;
  logic        strobe_last;
  logic [3:0]  strobe_nib;
  logic        advance;
  logic        in_acc;

  always_comb begin
    ld_go   = 1'b1;
    ld_job  = JOB_BYTE;
    ld_rs   = 1'b0;
    ld_byte = byte_value_i;
    ld_exp  = 3'd0;
    ld_pt   = 1'b0;
    ld_n    = POINT_DIGITS;
    row_idx = 2'(row_i - 3'd1);
    priority if (digit_count_i == 3'd0) begin
      ndig = 3'd1;
    end else if (digit_count_i > MaxDig) begin
      ndig = MaxDig;
    end else begin
      ndig = digit_count_i;
    end
    unique case (cmd_e'(command_i))
      CMD_INIT: begin
        ld_job = JOB_INIT;
      end
      CMD_CLEAR: begin
        ld_byte = INSTR_CLEAR;
      end
      CMD_INSTR: begin
        ld_rs = 1'b0;
      end
      CMD_CHAR: begin
        ld_rs = 1'b1;
      end
      CMD_CURSOR: begin
        ld_go   = (row_i >= 3'd1) && (row_i <= 3'd4);
        ld_byte = row_base(row_idx) + {3'b000, column_i} - 8'd1;
      end
      CMD_NUMBER: begin
        ld_job = JOB_DIGITS;
        ld_rs  = 1'b1;
        ld_n   = ndig;
        ld_exp = ndig - 3'd1;
      end
      CMD_POINT: begin
        ld_job = JOB_DIGITS;
        ld_rs  = 1'b1;
        ld_exp = POINT_EXP;
        ld_pt  = 1'b1;
      end
      default: begin
        ld_go = 1'b0;
      end
    endcase
    cap = pow10(ld_n) - 17'd1;
    if ({3'b000, number_i} > cap) begin
      ld_val = cap[13:0];
    end else begin
      ld_val = number_i;
    end
  end

  always_comb begin
    pw      = pow10(exp_q);
    digit   = 4'd0;
    sel_thr = 17'd0;
    thr     = 17'd0;
    for (int k = 1; k <= 9; k++) begin
      thr = 17'(pw * 17'(k));
      if ({3'b000, val_q} >= thr) begin
        digit   = 4'(k);
        sel_thr = thr;
      end
    end
    unique case (job_q)
      JOB_INIT: begin
        cur_byte = power_up_byte(pos_q);
        byte_end = (pos_q == INIT_LAST);
      end
      JOB_DIGITS: begin
        cur_byte = (pt_q && exp_q == 3'd0) ? ASCII_POINT : ASCII_ZERO + {4'b0000, digit};
        byte_end = (exp_q == 3'd0) && !pt_q;
      end
      default: begin
        cur_byte = byte_q;
        byte_end = 1'b1;
      end
    endcase
    strobe_last = !hi_q && byte_end;
    strobe_nib  = hi_q ? cur_byte[7:4] : cur_byte[3:0];
  end

  assign advance     = active_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = active_q && !(advance && strobe_last);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    active_d = active_q;
    if (in_acc && ld_go) begin
      active_d = 1'b1;
    end else if (advance && strobe_last) begin
      active_d = 1'b0;
    end
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ld_go) begin
      job_q  <= ld_job;
      rs_q   <= ld_rs;
      byte_q <= ld_byte;
      val_q  <= ld_val;
      exp_q  <= ld_exp;
      pt_q   <= ld_pt;
      pos_q  <= 3'd0;
      hi_q   <= 1'b1;
    end else if (advance) begin
      hi_q <= !hi_q;
      if (!hi_q) begin
        pos_q <= pos_q + 3'd1;
        if (pt_q && exp_q == 3'd0) begin
          pt_q <= 1'b0;
        end else begin
          val_q <= val_q - sel_thr[13:0];
          exp_q <= exp_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rs_q   <= rs_q;
      out_nib_q  <= strobe_nib;
      out_last_q <= strobe_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = out_rs_q;
  assign nibble_o          = out_nib_q;
  assign last_o            = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/clni_checker.sv
// ---------------------------------------------------------------------------
// Character LCD nibble interface checker
// Port-level assertions, bound to every instance of the interface.
// ---------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_interface_assert.svh"

module clni_checker
  import clni_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  command_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        register_select_o,
  input wire logic [3:0]  nibble_o,
  input wire logic        last_o
);

  `CLNI_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "stalled output transaction was dropped")
  `CLNI_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i, $stable(nibble_o) && $stable(register_select_o) && $stable(last_o), "stalled output payload changed")
  `CLNI_ASSERT(a_stall_after_accept, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o), "input stall rose without an accepted transaction")
  `CLNI_ASSERT(a_clear_emits, in_valid_i && !in_stall_o && command_i == CMD_CLEAR |-> ##2 out_valid_o, "clear request produced no strobe")

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);

`default_nettype wire

// File: sim/char_lcd_nibble_interface_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Character LCD nibble interface checker
// Watches both channels of the LCD interface, works out the bus strobes that
// each accepted request must produce and compares every accepted strobe with
// the oldest one still outstanding.
// ---------------------------------------------------------------------------

module char_lcd_nibble_interface_checker
  import clni_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [7:0]  byte_value_i,
  input  logic [2:0]  row_i,
  input  logic [4:0]  column_i,
  input  logic [13:0] number_i,
  input  logic [2:0]  digit_count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        register_select_i,
  input  logic [3:0]  nibble_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned strobe_count_o
);

  localparam logic [55:0] POWER_UP_SEQ = 56'h02_28_0e_0c_06_01_80;
  localparam logic [31:0] ROW_BASES    = 32'h80_c0_94_d4;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } lcd_strobe_t;

  lcd_strobe_t lcd_strobes_q[$];
  lcd_strobe_t expected_strobe;
  int unsigned fail_count   = 0;
  int unsigned strobe_count = 0;

  assign fail_count_o   = fail_count;
  assign pending_o      = lcd_strobes_q.size();
  assign strobe_count_o = strobe_count;

  function automatic void push_byte(input logic rs, input logic [7:0] value);
    lcd_strobes_q.push_back('{rs: rs, nibble: value[7:4], last: 1'b0});
    lcd_strobes_q.push_back('{rs: rs, nibble: value[3:0], last: 1'b0});
  endfunction

  function automatic void push_digits(input logic [13:0] num, input int unsigned digits,
                                      input bit point);
    int unsigned cap;
    int unsigned value;
    int unsigned scale;
    cap = 1;
    for (int i = 0; i < digits; i++) cap = cap * 10;
    scale = cap / 10;
    cap   = cap - 1;
    value = (num > cap) ? cap : num;
    for (int k = digits - 1; k >= 0; k--) begin
      if (point && k == 0) push_byte(1'b1, ASCII_POINT);
      push_byte(1'b1, ASCII_ZERO + 8'((value / scale) % 10));
      scale = scale / 10;
    end
  endfunction

  function automatic void predict_request(input logic [2:0] cmd, input logic [7:0] byte_val,
                                          input logic [2:0] row, input logic [4:0] col,
                                          input logic [13:0] num, input logic [2:0] dc);
    int unsigned first;
    int unsigned digits;
    first = lcd_strobes_q.size();
    case (cmd)
      CMD_INIT: begin
        for (int i = 0; i < 7; i++) push_byte(1'b0, POWER_UP_SEQ[8 * (6 - i) +: 8]);
      end
      CMD_CLEAR: push_byte(1'b0, INSTR_CLEAR);
      CMD_INSTR: push_byte(1'b0, byte_val);
      CMD_CHAR:  push_byte(1'b1, byte_val);
      CMD_CURSOR: begin
        if (row >= 3'd1 && row <= 3'd4) begin
          push_byte(1'b0, 8'(ROW_BASES[8 * (4 - row) +: 8] + col - 1));
        end
      end
      CMD_NUMBER: begin
        digits = (dc == 3'd0) ? 1 : ((dc > MAX_DIGITS) ? MAX_DIGITS : dc);
        push_digits(num, digits, 1'b0);
      end
      CMD_POINT: push_digits(num, 3, 1'b1);
      default: ;
    endcase
    if (lcd_strobes_q.size() > first) lcd_strobes_q[lcd_strobes_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        strobe_count++;
        if (lcd_strobes_q.size() == 0) begin
          $error("Unexpected strobe: register_select %0d, nibble %h, last %0d",
                 register_select_i, nibble_i, last_i);
          fail_count++;
        end else begin
          expected_strobe = lcd_strobes_q.pop_front();
          if (register_select_i !== expected_strobe.rs) begin
            $error("register_select: expected %0d, actual %0d",
                   expected_strobe.rs, register_select_i);
            fail_count++;
          end
          if (nibble_i !== expected_strobe.nibble) begin
            $error("nibble: expected %h, actual %h", expected_strobe.nibble, nibble_i);
            fail_count++;
          end
          if (last_i !== expected_strobe.last) begin
            $error("last: expected %0d, actual %0d", expected_strobe.last, last_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(command_i, byte_value_i, row_i, column_i, number_i, digit_count_i);
      end
    end
  end

endmodule

// File: sim/char_lcd_nibble_interface_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Character LCD nibble interface testbench
// Sends directed and random display requests with random gaps and output
// stalls; the checker beside the block predicts and compares every strobe.
// ---------------------------------------------------------------------------

module char_lcd_nibble_interface_tb;
  import clni_pkg::*;

  localparam logic [2:0]  CMD_UNUSED  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i     = '0;
  logic [7:0]  byte_value_i  = '0;
  logic [2:0]  row_i         = '0;
  logic [4:0]  column_i      = '0;
  logic [13:0] number_i      = '0;
  logic [2:0]  digit_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        register_select_o;
  logic [3:0]  nibble_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned strobe_count;
  int unsigned request_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned stall_left    = 0;
  bit          quiet         = 1'b0;

  char_lcd_nibble_interface i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .byte_value_i      (byte_value_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .number_i          (number_i),
    .digit_count_i     (digit_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .register_select_o (register_select_o),
    .nibble_o          (nibble_o),
    .last_o            (last_o)
  );

  char_lcd_nibble_interface_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .command_i         (command_i),
    .byte_value_i      (byte_value_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .number_i          (number_i),
    .digit_count_i     (digit_count_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .register_select_i (register_select_o),
    .nibble_i          (nibble_o),
    .last_i            (last_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .strobe_count_o    (strobe_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d strobes outstanding.", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] byte_val,
                              input logic [2:0] row, input logic [4:0] col,
                              input logic [13:0] num, input logic [2:0] dc);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    byte_value_i  <= byte_val;
    row_i         <= row;
    column_i      <= col;
    number_i      <= num;
    digit_count_i <= dc;
    do @(posedge clk_i); while (in_stall_o);
    request_count++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_request();
    logic [2:0]  cmd;
    logic [2:0]  row;
    logic [4:0]  col;
    logic [13:0] num;
    logic [2:0]  dc;
    int unsigned k;
    cmd = ($urandom_range(0, 19) == 0) ? CMD_INIT : 3'($urandom_range(1, 7));
    row = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    col = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 20));
    dc  = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    k   = $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0:       num = 14'($urandom_range(0, 99));
      1:       num = 14'($urandom_range(0, 9999));
      2:       num = 14'($urandom);
      default: num = 14'((10 ** k) - $urandom_range(0, 1));
    endcase
    send_request(cmd, 8'($urandom), row, col, num, dc);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_INIT,   8'h00, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_CLEAR,  8'h00, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_INSTR,  8'h00, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_INSTR,  8'hff, 3'd7, 5'd31, 14'h3fff,  3'd7);
    send_request(CMD_CHAR,   8'h00, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_CHAR,   8'hff, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_CHAR,   8'ha5, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd1, 5'd1,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd2, 5'd20, 14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd3, 5'd7,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd4, 5'd31, 14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd1, 5'd0,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd0, 5'd5,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd5, 5'd3,  14'd0,     3'd0);
    send_request(CMD_CURSOR, 8'h00, 3'd7, 5'd31, 14'd0,     3'd0);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'd0,     3'd1);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'd9999,  3'd4);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'h3fff,  3'd4);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'd57,    3'd0);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'd1234,  3'd5);
    send_request(CMD_NUMBER, 8'h00, 3'd0, 5'd0,  14'h3fff,  3'd7);
    send_request(CMD_POINT,  8'h00, 3'd0, 5'd0,  14'd0,     3'd0);
    send_request(CMD_POINT,  8'h00, 3'd0, 5'd0,  14'h3fff,  3'd0);
    send_request(CMD_POINT,  8'h00, 3'd0, 5'd0,  14'd42,    3'd0);
    send_request(CMD_UNUSED, 8'hff, 3'd1, 5'd1,  14'd1,     3'd1);

    for (int i = 0; i < 180; i++) begin
      if (i % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d display requests covering every command code, rows and digit counts",
             request_count);
    $display("in and out of range, and clamped numbers; %0d bus strobes were compared.",
             strobe_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: char_lcd_nibble_interface.f
+incdir+hw/rtl
hw/rtl/clni_pkg.sv
hw/rtl/char_lcd_nibble_interface.sv
hw/rtl/clni_checker.sv
sim/char_lcd_nibble_interface_checker.sv
sim/char_lcd_nibble_interface_tb.sv
